>>> rtl/sksu_pkg.sv
// ----------------------------------------------------------------------------
// sksu_pkg
// Shared types and codes for the sorted key range search unit.
// ----------------------------------------------------------------------------
package sksu_pkg;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_BIS  = 8'b0000_0010,
      S_BCHK = 8'b0000_0100,
      S_DOWN = 8'b0000_1000,
      S_DCHK = 8'b0001_0000,
      S_UP   = 8'b0010_0000,
      S_UCHK = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

>>> rtl/sksu_key_mem.sv
// ----------------------------------------------------------------------------
// sksu_key_mem
// Key table RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sksu_key_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 24
) (
   input  logic                 clock,
   input  sksu_pkg::mem_ctl_type ctl,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [DATA_W-1:0]    wr_data,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [DATA_W-1:0]    rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sorted_key_range_search_unit.sv
// Clear and append complete on acceptance in idle; a query does one bisection
// step (memory read, then compare) per probe over at most ceil(log2(entries+1))
// steps, then walks neighbor entries down and up (read, then compare each), then
// presents the result; a stalled result word holds off the next word.
// Reset (synchronous, active high) empties the table and drops any pending
// result; key RAM contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_key_range_search_unit
// Sorted key table with append/clear and bisecting range query.
// ----------------------------------------------------------------------------
module sorted_key_range_search_unit #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_BITS    = 24,
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
   localparam int IN_W       = ((3 * KEY_BITS + 7) / 8) * 8,
   localparam int OUT_W      = ((2 * CNT_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [IN_W-1:0]  req_tdata,  // key_value, range_low, range_high
   input  logic [1:0]       req_tuser,  // kind
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OUT_W-1:0] rsp_tdata,  // first_index, last_index
   output logic             rsp_tuser   // found
);

   import sksu_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     first_ff, first_in;
   logic [CNT_W-1:0]     bound_ff, bound_in;
   logic [CNT_W-1:0]     down_ff, down_in;
   logic [CNT_W-1:0]     up_ff, up_in;
   logic                 found_ff, found_in;
   logic [KEY_BITS-1:0]  lo_ff, lo_in;
   logic [KEY_BITS-1:0]  hi_ff, hi_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]     rsp_first_ff, rsp_first_in;
   logic [CNT_W-1:0]     rsp_last_ff, rsp_last_in;
   logic                 rsp_found_ff, rsp_found_in;

   mem_ctl_type          mem_ctl;
   logic [ADDR_W-1:0]    rd_addr;
   logic [KEY_BITS-1:0]  rd_data;
   logic [CNT_W:0]       mid_sum;
   logic [CNT_W-1:0]     mid;
   logic [CNT_W-1:0]     down_m1;
   logic [CNT_W-1:0]     up_p1;
   logic                 accept;
   kind_type             kind;
   logic [KEY_BITS-1:0]  req_key;
   logic [KEY_BITS-1:0]  req_lo;
   logic [KEY_BITS-1:0]  req_hi;

   assign kind    = kind_type'(req_tuser);
   assign req_key = req_tdata[KEY_BITS-1:0];
   assign req_lo  = req_tdata[2*KEY_BITS-1:KEY_BITS];
   assign req_hi  = req_tdata[3*KEY_BITS-1:2*KEY_BITS];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // bound is exclusive: mid = floor((first + bound - 1) / 2)
   assign mid_sum = {1'b0, first_ff} + {1'b0, bound_ff} - (CNT_W + 1)'(1);
   assign mid     = mid_sum[CNT_W:1];
   assign down_m1 = down_ff - CNT_W'(1);
   assign up_p1   = up_ff + CNT_W'(1);

   sksu_key_mem #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (KEY_BITS)
   ) u_key_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_key),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      first_in     = first_ff;
      bound_in     = bound_ff;
      down_in      = down_ff;
      up_in        = up_ff;
      found_in     = found_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_first_in = rsp_first_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_found_in = rsp_found_ff;
      mem_ctl      = '0;
      rd_addr      = mid[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (kind)
                  KIND_CLEAR: begin
                     count_in = '0;
                  end
                  KIND_APPEND: begin
                     if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                        mem_ctl.wr_en = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_QUERY: begin
                     lo_in    = req_lo;
                     hi_in    = req_hi;
                     first_in = '0;
                     bound_in = count_ff;
                     state_in = S_BIS;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_BIS: begin
            if (first_ff < bound_ff) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = mid[ADDR_W-1:0];
               down_in       = mid;
               state_in      = S_BCHK;
            end else begin
               down_in  = count_ff;
               up_in    = count_ff;
               found_in = 1'b0;
               state_in = S_DONE;
            end
         end
         S_BCHK: begin
            if (lo_ff > rd_data) begin
               first_in = down_ff + CNT_W'(1);
               state_in = S_BIS;
            end else if (hi_ff < rd_data) begin
               bound_in = down_ff;
               state_in = S_BIS;
            end else begin
               up_in    = down_ff;
               found_in = 1'b1;
               state_in = S_DOWN;
            end
         end
         S_DOWN: begin
            if (down_ff != '0) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = down_m1[ADDR_W-1:0];
               state_in      = S_DCHK;
            end else begin
               state_in = S_UP;
            end
         end
         S_DCHK: begin
            if (rd_data >= lo_ff) begin
               down_in  = down_m1;
               state_in = S_DOWN;
            end else begin
               state_in = S_UP;
            end
         end
         S_UP: begin
            if (up_p1 < count_ff) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = up_p1[ADDR_W-1:0];
               state_in      = S_UCHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_UCHK: begin
            if (rd_data <= hi_ff) begin
               up_in    = up_p1;
               state_in = S_UP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_first_in = down_ff;
               rsp_last_in  = up_ff;
               rsp_found_in = found_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      first_ff     <= first_in;
      bound_ff     <= bound_in;
      down_ff      <= down_in;
      up_ff        <= up_in;
      found_ff     <= found_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      rsp_first_ff <= rsp_first_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({rsp_last_ff, rsp_first_ff});
   assign rsp_tuser  = rsp_found_ff;

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_bchk_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BCHK) |-> (first_ff < bound_ff) && (down_ff < count_ff))
      else $error("bisection probe outside search window");

   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DCHK || state_ff == S_UCHK) |-> (down_ff <= up_ff) && found_ff)
      else $error("walk indices out of order");

   a_rd_idle: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |-> (state_ff == S_IDLE) && !mem_ctl.rd_en)
      else $error("key table write during search");
`endif

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_key_range_search_unit. A queue of words
// (directed corner cases, then runs of sorted appends followed by range
// queries, with noise and a full-table fill) feeds a stream driver. Every
// accepted word updates a local copy of the key table and count, and each
// query predicts first/last index and found. The response monitor checks
// words in order against those predictions. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sksu_pkg::*;

   localparam int DEPTH       = 1024;
   localparam int RAND_WORDS  = 1650;
   localparam int CYCLE_LIMIT = 20000000;
   localparam logic [23:0] KEY_MAX = 24'hFFFFFF;

   typedef struct {
      kind_type    kind;
      logic [23:0] key;
      logic [23:0] lo;
      logic [23:0] hi;
      bit          calm;
   } search_req_type;

   typedef struct {
      logic [10:0] first;
      logic [10:0] last;
      logic        found;
   } span_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;  // key_value, range_low, range_high
   logic [1:0]  req_tuser = '0;  // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;       // first_index, last_index
   logic        rsp_tuser;       // found

   search_req_type pending[$];
   span_type       span_queue[$];
   logic [23:0]    key_mem [DEPTH];
   int             key_count = 0;

   search_req_type drv_word;
   bit          drive_calm = 1'b0;
   bit          req_taken = 1'b0;
   int          cycle_count = 0;
   int          errors = 0;

   logic [23:0] gen_keys[$];
   bit          gen_calm = 1'b0;
   int          rand_count = 0;

   sorted_key_range_search_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [23:0] sat_add(input logic [23:0] a, input int unsigned b);
      logic [24:0] sum;
      sum = {1'b0, a} + 25'(b);
      return sum[24] ? KEY_MAX : sum[23:0];
   endfunction

   function automatic logic [23:0] sat_sub(input logic [23:0] a, input int unsigned b);
      return (a < 24'(b)) ? 24'd0 : a - 24'(b);
   endfunction

   // bisect to any in-range entry, then walk out to the ends of the run
   function automatic span_type locate_range(input logic [23:0] lo, input logic [23:0] hi);
      int       first;
      int       last;
      int       mid;
      int       down;
      int       up;
      span_type s;
      first = 0;
      last = key_count - 1;
      s.first = 11'(key_count);
      s.last = 11'(key_count);
      s.found = 1'b0;
      while (first <= last) begin
         mid = (first + last) / 2;
         if (lo > key_mem[mid]) begin
            first = mid + 1;
         end else if (hi < key_mem[mid]) begin
            last = mid - 1;
         end else begin
            down = mid;
            up = mid;
            while (down - 1 >= 0 && key_mem[down - 1] >= lo) down--;
            while (up + 1 < key_count && key_mem[up + 1] <= hi) up++;
            s.first = 11'(down);
            s.last = 11'(up);
            s.found = 1'b1;
            return s;
         end
      end
      return s;
   endfunction

   task automatic push_word(input kind_type kind, input logic [23:0] key,
                            input logic [23:0] lo, input logic [23:0] hi);
      search_req_type w;
      w.kind = kind;
      w.key = key;
      w.lo = lo;
      w.hi = hi;
      w.calm = gen_calm;
      pending = {pending, w};
      if (kind != KIND_NONE) rand_count++;
   endtask

   task automatic push_append(input logic [23:0] key);
      push_word(KIND_APPEND, key, 24'($urandom_range(0, KEY_MAX)),
                24'($urandom_range(0, KEY_MAX)));
      if (gen_keys.size() < DEPTH) gen_keys = {gen_keys, key};
   endtask

   task automatic push_query();
      int          i;
      int          j;
      int          t;
      logic [23:0] lo;
      logic [23:0] hi;
      lo = 24'($urandom_range(0, KEY_MAX));
      hi = 24'($urandom_range(0, KEY_MAX));
      case ($urandom_range(0, 5))
         1, 2, 3: begin
            if (gen_keys.size() > 0) begin
               i = $urandom_range(0, gen_keys.size() - 1);
               j = $urandom_range(0, gen_keys.size() - 1);
               if (i > j) begin
                  t = i;
                  i = j;
                  j = t;
               end
               lo = sat_sub(gen_keys[i], $urandom_range(0, 2));
               hi = sat_add(gen_keys[j], $urandom_range(0, 2));
               if ($urandom_range(0, 3) == 0) lo = sat_add(gen_keys[i], 1);
            end
         end
         4: begin
            lo = 24'($urandom_range(1, KEY_MAX));
            hi = 24'($urandom_range(0, lo - 1));
         end
         5: begin
            if (gen_keys.size() > 0) lo = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
            hi = lo;
         end
         default: ;
      endcase
      push_word(KIND_QUERY, 24'($urandom_range(0, KEY_MAX)), lo, hi);
   endtask

   // driver: holds a word until taken, may idle between words
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (pending.size() > 0 && (drive_calm || $urandom_range(0, 99) >= 13)) begin
               drv_word = pending.pop_front();
               drive_calm = drv_word.calm;
               req_tvalid <= 1'b1;
               req_tdata <= {drv_word.hi, drv_word.lo, drv_word.key};
               req_tuser <= drv_word.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= drive_calm || ($urandom_range(0, 99) >= 13);
      end
   end

   // monitor: responses are checked before the same-edge request is applied
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         cycle_count++;
         if (rsp_tvalid && rsp_tready) begin
            if (span_queue.size() == 0) begin
               $display("%0t: unexpected word first=%0d last=%0d found=%0b", $time,
                        rsp_tdata[10:0], rsp_tdata[21:11], rsp_tuser);
               errors++;
            end else begin
               span_type e;
               e = span_queue.pop_front();
               if (rsp_tdata[10:0] !== e.first) begin
                  $display("%0t: first_index expected %0d, got %0d", $time,
                           e.first, rsp_tdata[10:0]);
                  errors++;
               end
               if (rsp_tdata[21:11] !== e.last) begin
                  $display("%0t: last_index expected %0d, got %0d", $time,
                           e.last, rsp_tdata[21:11]);
                  errors++;
               end
               if (rsp_tuser !== e.found) begin
                  $display("%0t: found expected %0b, got %0b", $time, e.found, rsp_tuser);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            case (kind_type'(req_tuser))
               KIND_CLEAR: key_count = 0;
               KIND_APPEND: begin
                  if (key_count < DEPTH) begin
                     key_mem[key_count] = req_tdata[23:0];
                     key_count++;
                  end
               end
               KIND_QUERY: span_queue = {span_queue, locate_range(req_tdata[47:24],
                                                                  req_tdata[71:48])};
               default: ;
            endcase
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("** sorted_key_range_search_unit: FAILED **");
      $finish;
   end

   initial begin
      int          seq_idx;
      int          fill_at;
      int          n;
      int unsigned spread;
      logic [23:0] base;

      // directed corners
      push_word(KIND_QUERY, 24'd0, 24'd0, KEY_MAX);
      push_word(KIND_NONE, KEY_MAX, KEY_MAX, KEY_MAX);
      push_append(24'd0);
      push_append(KEY_MAX);
      push_word(KIND_QUERY, KEY_MAX, 24'd0, 24'd0);
      push_word(KIND_QUERY, 24'd0, KEY_MAX, KEY_MAX);
      push_word(KIND_QUERY, 24'd0, 24'd0, KEY_MAX);
      push_word(KIND_QUERY, 24'd0, KEY_MAX, 24'd0);
      push_word(KIND_QUERY, 24'd0, 24'd1, KEY_MAX - 24'd1);
      push_word(KIND_CLEAR, KEY_MAX, KEY_MAX, KEY_MAX);
      gen_keys.delete();
      push_word(KIND_QUERY, 24'd0, 24'd0, KEY_MAX);
      push_append(24'd10);
      push_append(24'd20);
      push_append(24'd20);
      push_append(24'd20);
      push_append(24'd30);
      push_word(KIND_QUERY, 24'd0, 24'd20, 24'd20);
      push_word(KIND_QUERY, 24'd0, 24'd15, 24'd25);
      push_word(KIND_QUERY, 24'd0, 24'd0, 24'd9);
      push_word(KIND_QUERY, 24'd0, 24'd31, KEY_MAX);
      push_word(KIND_NONE, 24'd0, 24'd0, 24'd0);
      push_append(24'd5);   // out of order
      push_word(KIND_QUERY, 24'd0, 24'd0, KEY_MAX);
      push_word(KIND_QUERY, 24'd0, 24'd5, 24'd5);

      rand_count = 0;
      seq_idx = 0;
      fill_at = $urandom_range(2, 8);
      while (rand_count < RAND_WORDS) begin
         gen_calm = (seq_idx == 5);
         if (seq_idx == fill_at) begin
            // fill past capacity so the last appends are dropped
            push_word(KIND_CLEAR, 24'($urandom_range(0, KEY_MAX)), 24'd0, 24'd0);
            gen_keys.delete();
            base = 24'($urandom_range(0, 100));
            for (int i = 0; i < DEPTH + 6; i++) begin
               push_append(base);
               if ($urandom_range(0, 9) != 0) base = sat_add(base, $urandom_range(0, 16000));
            end
            for (int i = 0; i < 8; i++) push_query();
         end else begin
            if (gen_keys.size() > 900 || $urandom_range(0, 7) != 0) begin
               push_word(KIND_CLEAR, 24'($urandom_range(0, KEY_MAX)),
                         24'($urandom_range(0, KEY_MAX)), 24'($urandom_range(0, KEY_MAX)));
               gen_keys.delete();
            end
            case ($urandom_range(0, 3))
               0: spread = 3;
               1: spread = 255;
               2: spread = 65535;
               default: spread = 1 << 22;
            endcase
            case ($urandom_range(0, 3))
               0: base = 24'($urandom_range(0, 255));
               1: base = KEY_MAX - 24'($urandom_range(0, 4095));
               default: base = 24'($urandom_range(0, KEY_MAX));
            endcase
            if (gen_keys.size() > 0) base = gen_keys[$];
            n = $urandom_range(0, 24);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(0, 11))
                  0: push_word(KIND_NONE, 24'($urandom_range(0, KEY_MAX)),
                               24'($urandom_range(0, KEY_MAX)),
                               24'($urandom_range(0, KEY_MAX)));
                  1: push_append(24'($urandom_range(0, KEY_MAX)));
                  default: ;
               endcase
               push_append(base);
               base = sat_add(base, $urandom_range(0, spread));
            end
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) push_query();
         end
         seq_idx++;
      end
      gen_calm = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      while (pending.size() > 0 || req_tvalid) @(posedge clock);
      while (span_queue.size() > 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (span_queue.size() > 0) begin
         $display("%0t: %0d expected words never arrived", $time, span_queue.size());
         errors++;
      end
      if (errors == 0) begin
         $display("** sorted_key_range_search_unit: PASSED **");
      end else begin
         $display("** sorted_key_range_search_unit: FAILED **");
      end
      $finish;
   end

endmodule
